>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define QRD_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define QRD_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hdl/qrd_pkg.sv
// Shared types and constants of the QOI RGB stream decoder.
package qrd_pkg;

  // Request kinds.
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Fault codes.
  localparam logic [1:0] FAULT_NONE       = 2'd0;
  localparam logic [1:0] FAULT_EMPTY_SLOT = 2'd1;
  localparam logic [1:0] FAULT_EARLY_END  = 2'd2;

  // Tag bytes and tag classes (top two bits of a tag byte).
  localparam logic [7:0] TAG_RGB    = 8'hFE;
  localparam logic [1:0] TAGC_INDEX = 2'b00;
  localparam logic [1:0] TAGC_DIFF  = 2'b01;
  localparam logic [1:0] TAGC_LUMA  = 2'b10;
  localparam logic [1:0] TAGC_RUN   = 2'b11;

  // Parser phases and delta biases.
  localparam logic [1:0] PHASE_TAG      = 2'd0;
  localparam logic [1:0] PHASE_FIRST    = 2'd1;
  localparam logic [1:0] PHASE_RGB_LAST = 2'd3;
  localparam logic [7:0] DIFF_BIAS      = 8'd2;
  localparam logic [7:0] LUMA_G_BIAS    = 8'd32;
  localparam logic [7:0] LUMA_RB_BIAS   = 8'd8;

  // Previous pixel before any color has been decoded.
  localparam logic [31:0] PIXEL_NONE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] region_width;
    logic [15:0] region_height;
  } req_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        last_of_region;
    logic [1:0]  fault;
  } rsp_t;

  // What the datapath will do with the request it holds.
  typedef enum logic [2:0] {
    OP_IGNORE,
    OP_START,
    OP_LATCH,
    OP_COLOR,
    OP_INDEX,
    OP_RUN,
    OP_FAULT
  } op_t;

  typedef struct packed {
    logic load_req;
    logic execute;
    logic index_done;
    logic run_step;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic run_more;
  } status_t;

endpackage

>>> hdl/qrd_ctrl.sv
// Controller state machine of the QOI RGB stream decoder.
module qrd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  input  qrd_pkg::status_t status,
  output qrd_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_INDEX  = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Handshake outputs follow the state alone.
  assign req_stall = (state != S_IDLE);
  assign rsp_valid = (state == S_EMIT);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.execute = 1'b1;
        case (status.op)
          qrd_pkg::OP_COLOR, qrd_pkg::OP_RUN, qrd_pkg::OP_FAULT: state_next = S_EMIT;
          qrd_pkg::OP_INDEX: state_next = S_INDEX;
          default: state_next = S_IDLE;
        endcase
      end
      S_INDEX: begin
        // The cache read data is registered and ready now.
        cmd.index_done = 1'b1;
        state_next     = S_EMIT;
      end
      S_EMIT: begin
        if (!rsp_stall) begin
          if (status.run_more) begin
            cmd.run_step = 1'b1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hdl/qrd_datapath.sv
// Datapath of the QOI RGB stream decoder: parser state, color cache and result register.
module qrd_datapath #(
  parameter int CACHE_ENTRIES = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  qrd_pkg::req_t    req,
  input  qrd_pkg::cmd_t    cmd,
  output qrd_pkg::rsp_t    rsp,
  output qrd_pkg::status_t status
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);

  qrd_pkg::req_t     req_q;
  qrd_pkg::op_t      op;
  logic [1:0]        fault_code;
  logic [31:0]       pixels_left;
  logic [31:0]       pixels_left_dec;
  logic              last_pixel;
  logic              halted;
  logic [1:0]        parse_phase;
  logic [15:0]       partial_bytes;
  logic [7:0]        pending_tag;
  logic [31:0]       previous_pixel;
  logic [5:0]        run_left;
  logic [CACHE_ENTRIES-1:0] cache_valid;
  logic [23:0]       cache_mem [CACHE_ENTRIES];
  logic [23:0]       cache_rd;
  logic [IDX_W-1:0]  read_idx;
  logic [IDX_W-1:0]  write_idx;
  logic [7:0]        pr, pg, pb;
  logic [7:0]        new_r, new_g, new_b;
  logic [7:0]        luma_g, luma_r, luma_b;
  logic [5:0]        hash;
  logic [6:0]        run_len;
  logic [6:0]        run_first;
  logic [31:0]       region_area;
  logic              active;

  // Request register.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req;
    end
  end

  assign active          = !halted && (pixels_left != 32'd0);
  assign pixels_left_dec = pixels_left - 32'd1;
  assign last_pixel      = (pixels_left == 32'd1);
  assign read_idx        = IDX_W'(req_q.data_byte[5:0]);
  assign region_area     = req_q.region_width * req_q.region_height;

  // Classify the held request against the parser state.
  always_comb begin
    op         = qrd_pkg::OP_IGNORE;
    fault_code = qrd_pkg::FAULT_NONE;
    case (req_q.kind)
      qrd_pkg::KIND_START: op = qrd_pkg::OP_START;
      qrd_pkg::KIND_END: begin
        if (active) begin
          op         = qrd_pkg::OP_FAULT;
          fault_code = qrd_pkg::FAULT_EARLY_END;
        end
      end
      qrd_pkg::KIND_DATA: begin
        if (active) begin
          if (parse_phase != qrd_pkg::PHASE_TAG) begin
            if (pending_tag == qrd_pkg::TAG_RGB && parse_phase != qrd_pkg::PHASE_RGB_LAST) begin
              op = qrd_pkg::OP_LATCH;
            end else begin
              op = qrd_pkg::OP_COLOR;
            end
          end else if (req_q.data_byte == qrd_pkg::TAG_RGB) begin
            op = qrd_pkg::OP_LATCH;
          end else begin
            case (req_q.data_byte[7:6])
              qrd_pkg::TAGC_INDEX: begin
                if (cache_valid[read_idx]) begin
                  op = qrd_pkg::OP_INDEX;
                end else begin
                  op         = qrd_pkg::OP_FAULT;
                  fault_code = qrd_pkg::FAULT_EMPTY_SLOT;
                end
              end
              qrd_pkg::TAGC_DIFF: op = qrd_pkg::OP_COLOR;
              qrd_pkg::TAGC_LUMA: op = qrd_pkg::OP_LATCH;
              qrd_pkg::TAGC_RUN:  op = qrd_pkg::OP_RUN;
              default: op = qrd_pkg::OP_IGNORE;
            endcase
          end
        end
      end
      default: op = qrd_pkg::OP_IGNORE;
    endcase
  end

  // New color from an RGB, LUMA or DIFF tag; components wrap mod 256.
  assign pr     = previous_pixel[23:16];
  assign pg     = previous_pixel[15:8];
  assign pb     = previous_pixel[7:0];
  assign luma_g = {2'b00, pending_tag[5:0]} - qrd_pkg::LUMA_G_BIAS;
  assign luma_r = luma_g - qrd_pkg::LUMA_RB_BIAS + {4'b0000, req_q.data_byte[7:4]};
  assign luma_b = luma_g - qrd_pkg::LUMA_RB_BIAS + {4'b0000, req_q.data_byte[3:0]};

  always_comb begin
    if (parse_phase != qrd_pkg::PHASE_TAG && pending_tag == qrd_pkg::TAG_RGB) begin
      new_r = partial_bytes[15:8];
      new_g = partial_bytes[7:0];
      new_b = req_q.data_byte;
    end else if (parse_phase != qrd_pkg::PHASE_TAG) begin
      new_r = pr + luma_r;
      new_g = pg + luma_g;
      new_b = pb + luma_b;
    end else begin
      new_r = pr + {6'b0, req_q.data_byte[5:4]} - qrd_pkg::DIFF_BIAS;
      new_g = pg + {6'b0, req_q.data_byte[3:2]} - qrd_pkg::DIFF_BIAS;
      new_b = pb + {6'b0, req_q.data_byte[1:0]} - qrd_pkg::DIFF_BIAS;
    end
  end

  // Cache slot 3r + 5g + 7b mod 64, built from shifts in six bits.
  assign hash = new_r[5:0] + {new_r[4:0], 1'b0}
              + new_g[5:0] + {new_g[3:0], 2'b00}
              + {new_b[2:0], 3'b000} - new_b[5:0];
  assign write_idx = IDX_W'(hash);

  // Run length, cut at the region end.
  assign run_len   = {1'b0, req_q.data_byte[5:0]} + 7'd1;
  assign run_first = (pixels_left < {25'b0, run_len}) ? pixels_left[6:0] : run_len;

  // Parser and region state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_left    <= 32'd0;
      halted         <= 1'b0;
      parse_phase    <= qrd_pkg::PHASE_TAG;
      partial_bytes  <= 16'd0;
      pending_tag    <= 8'd0;
      previous_pixel <= qrd_pkg::PIXEL_NONE;
      run_left       <= 6'd0;
      cache_valid    <= '0;
    end else if (cmd.execute) begin
      case (op)
        qrd_pkg::OP_START: begin
          pixels_left    <= region_area;
          halted         <= 1'b0;
          parse_phase    <= qrd_pkg::PHASE_TAG;
          partial_bytes  <= 16'd0;
          pending_tag    <= 8'd0;
          previous_pixel <= qrd_pkg::PIXEL_NONE;
          run_left       <= 6'd0;
          cache_valid    <= '0;
        end
        qrd_pkg::OP_FAULT: begin
          halted      <= 1'b1;
          parse_phase <= qrd_pkg::PHASE_TAG;
        end
        qrd_pkg::OP_LATCH: begin
          if (parse_phase == qrd_pkg::PHASE_TAG) begin
            pending_tag   <= req_q.data_byte;
            partial_bytes <= 16'd0;
            parse_phase   <= qrd_pkg::PHASE_FIRST;
          end else begin
            partial_bytes <= {partial_bytes[7:0], req_q.data_byte};
            parse_phase   <= parse_phase + 2'd1;
          end
        end
        qrd_pkg::OP_COLOR: begin
          parse_phase            <= qrd_pkg::PHASE_TAG;
          previous_pixel         <= {8'h00, new_r, new_g, new_b};
          cache_valid[write_idx] <= 1'b1;
          pixels_left            <= pixels_left_dec;
        end
        qrd_pkg::OP_RUN: begin
          pixels_left <= pixels_left_dec;
          run_left    <= 6'(run_first - 7'd1);
        end
        default: begin
        end
      endcase
    end else if (cmd.index_done) begin
      previous_pixel <= {8'h00, cache_rd};
      pixels_left    <= pixels_left_dec;
    end else if (cmd.run_step) begin
      pixels_left <= pixels_left_dec;
      run_left    <= run_left - 6'd1;
    end
  end

  // Color cache memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.execute && op == qrd_pkg::OP_COLOR) begin
      cache_mem[write_idx] <= {new_r, new_g, new_b};
    end
    cache_rd <= cache_mem[read_idx];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      case (op)
        qrd_pkg::OP_COLOR: begin
          rsp.pixel          <= {8'h00, new_r, new_g, new_b};
          rsp.last_of_region <= last_pixel;
          rsp.fault          <= qrd_pkg::FAULT_NONE;
        end
        qrd_pkg::OP_RUN: begin
          rsp.pixel          <= previous_pixel;
          rsp.last_of_region <= last_pixel;
          rsp.fault          <= qrd_pkg::FAULT_NONE;
        end
        qrd_pkg::OP_FAULT: begin
          rsp.pixel          <= 32'd0;
          rsp.last_of_region <= 1'b1;
          rsp.fault          <= fault_code;
        end
        default: begin
        end
      endcase
    end else if (cmd.index_done) begin
      rsp.pixel          <= {8'h00, cache_rd};
      rsp.last_of_region <= last_pixel;
      rsp.fault          <= qrd_pkg::FAULT_NONE;
    end else if (cmd.run_step) begin
      rsp.pixel          <= previous_pixel;
      rsp.last_of_region <= last_pixel;
      rsp.fault          <= qrd_pkg::FAULT_NONE;
    end
  end

  assign status.op       = op;
  assign status.run_more = (run_left != 6'd0);

endmodule

>>> hdl/qoi_rgb_stream_decoder.sv
// Top level of the QOI RGB stream decoder.
// Each request is registered in the idle state and decoded in the decode state,
// so a request that yields no pixel (start, a tag byte that waits for more
// bytes, an ignored byte) goes straight back to idle. A request that yields a
// single pixel goes on to the emit state, where the pixel waits in the result
// register until it is taken; an INDEX tag first passes an index state for the
// registered read of the color cache memory. A RUN tag of n pixels delivers one
// pixel per cycle after the first while the result side does not stall, and the
// request side is stalled until the run ends. A start request clears the cache
// valid bits at once and computes the pixel count with one 16 by 16 multiply.
module qoi_rgb_stream_decoder #(
  parameter int CACHE_ENTRIES = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  qrd_pkg::req_t req,
  input  logic          req_valid,
  output logic          req_stall,
  output qrd_pkg::rsp_t rsp,
  output logic          rsp_valid,
  input  logic          rsp_stall
);

  qrd_pkg::cmd_t    cmd;
  qrd_pkg::status_t status;

  // Sequencing of requests and results.
  qrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Parser, cache and result register.
  qrd_datapath #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .rsp    (rsp),
    .status (status)
  );

endmodule

>>> hdl/qrd_checker.sv
// Port-level checker of the QOI RGB stream decoder and its bind statement.
`include "assert_macros.svh"

module qrd_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_stall,
  input qrd_pkg::rsp_t rsp,
  input logic          rsp_valid,
  input logic          rsp_stall
);

  logic fault_rsp;
  logic code_known;
  logic rsp_held;

  // Shorthands for the properties below.
  assign fault_rsp  = rsp_valid && (rsp.fault != qrd_pkg::FAULT_NONE);
  assign code_known = (rsp.fault <= qrd_pkg::FAULT_EARLY_END);
  assign rsp_held   = rsp_valid && rsp_stall;

  // A fault result always closes the region.
  `QRD_ASSERT_IMPLY(a_fault_last, clk, rst, fault_rsp, rsp.last_of_region, "fault without last")

  // A fault result carries a zero pixel.
  `QRD_ASSERT_IMPLY(a_fault_pixel, clk, rst, fault_rsp, rsp.pixel == 32'd0, "fault pixel not zero")

  // The unused fault code never appears.
  `QRD_ASSERT_IMPLY(a_fault_code, clk, rst, rsp_valid, code_known, "undefined fault code")

  // No new request is taken while a result is pending.
  `QRD_ASSERT_IMPLY(a_hold_input, clk, rst, rsp_valid, req_stall, "request taken while result pending")

  // A stalled result stays valid and unchanged.
  `QRD_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_held, rsp_valid && $stable(rsp), "stalled result changed")

endmodule

bind qoi_rgb_stream_decoder qrd_checker u_qrd_checker (.*);
